### hw/rtl/ihc_pkg.sv
`default_nettype none

package ihc_pkg;

    localparam int WORD_W      = 16;
    localparam int COUNT_W     = 6;
    localparam int HLEN_W      = 4;
    localparam int TTL_W       = 8;
    localparam int ADDR_W      = 32;
    localparam int VERSION_W   = 4;

    localparam logic [VERSION_W-1:0] IPV4_VERSION = 4'd4;
    localparam logic [HLEN_W-1:0]    MIN_HLEN     = 4'd4;
    localparam logic [WORD_W-1:0]    SUM_GOOD     = 16'hffff;
    localparam logic [ADDR_W-1:0]    BCAST_ADDR   = 32'hffff_ffff;
    localparam logic [COUNT_W-1:0]   COUNT_MAX    = 6'd63;

    // word positions within the header
    localparam logic [COUNT_W-1:0]   IDX_VER_HLEN = 6'd0;
    localparam logic [COUNT_W-1:0]   IDX_TTL      = 6'd4;
    localparam logic [COUNT_W-1:0]   IDX_DST_HI   = 6'd8;
    localparam logic [COUNT_W-1:0]   IDX_DST_LO   = 6'd9;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_VERSION  = 3'd1,
        VERDICT_HLEN     = 3'd2,
        VERDICT_TTL      = 3'd3,
        VERDICT_CHECKSUM = 3'd4,
        VERDICT_DEST     = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [WORD_W-1:0] packet_word;
        logic              last_word;
    } ihc_in_t;

    typedef struct packed {
        verdict_t          verdict;
        logic [HLEN_W-1:0] header_words;
        logic [TTL_W-1:0]  time_to_live;
        logic              is_broadcast;
    } ihc_out_t;

endpackage

`default_nettype wire

### hw/rtl/ihc_core.sv
`default_nettype none

module ihc_core
    import ihc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire ihc_in_t           word_in,
    input  wire logic [ADDR_W-1:0] local_address,
    output ihc_out_t               result
);

    logic [COUNT_W-1:0]   word_count_reg, word_count_next;
    logic [WORD_W-1:0]    sum_reg, sum_next;
    logic [VERSION_W-1:0] version_reg, version_next;
    logic [HLEN_W-1:0]    hlen_reg, hlen_next;
    logic [TTL_W-1:0]     ttl_reg, ttl_next;
    logic [ADDR_W-1:0]    dest_reg, dest_next;

    logic [WORD_W-1:0]    w;
    logic [COUNT_W-1:0]   idx;
    logic [WORD_W:0]      raw_sum;
    logic [WORD_W-1:0]    folded_sum;
    logic [COUNT_W:0]     seen_words;
    logic [COUNT_W:0]     hdr_words16;
    logic                 short_pkt;
    verdict_t             verdict;

    assign w   = word_in.packet_word;
    assign idx = word_count_reg;

    always_comb begin
        version_next = version_reg;
        hlen_next    = hlen_reg;
        ttl_next     = ttl_reg;
        dest_next    = dest_reg;
        if (idx == IDX_VER_HLEN) begin
            version_next = w[15:12];
            hlen_next    = w[11:8];
        end else if (idx == IDX_TTL) begin
            ttl_next = w[15:8];
        end else if (idx == IDX_DST_HI) begin
            dest_next = {w, dest_reg[15:0]};
        end else if (idx == IDX_DST_LO) begin
            dest_next = {dest_reg[31:16], w};
        end
    end

    // header length in 16-bit words
    assign hdr_words16 = {2'b00, hlen_next, 1'b0};
    assign seen_words  = {1'b0, idx} + 7'd1;
    assign short_pkt   = seen_words < hdr_words16;

    // end-around-carry add
    assign raw_sum    = {1'b0, sum_reg} + {1'b0, w};
    assign folded_sum = raw_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw_sum[WORD_W]};

    always_comb begin
        sum_next = sum_reg;
        if ({1'b0, idx} < hdr_words16) begin
            sum_next = folded_sum;
        end
    end

    assign word_count_next = (word_count_reg == COUNT_MAX) ? COUNT_MAX
                                                           : word_count_reg + 6'd1;

    always_comb begin
        if (version_next != IPV4_VERSION) begin
            verdict = VERDICT_VERSION;
        end else if (hlen_next <= MIN_HLEN || short_pkt) begin
            verdict = VERDICT_HLEN;
        end else if (ttl_next == '0) begin
            verdict = VERDICT_TTL;
        end else if (sum_next != SUM_GOOD) begin
            verdict = VERDICT_CHECKSUM;
        end else if (dest_next != local_address && dest_next != BCAST_ADDR) begin
            verdict = VERDICT_DEST;
        end else begin
            verdict = VERDICT_OK;
        end
    end

    assign result = {verdict, hlen_next, ttl_next, (dest_next == BCAST_ADDR)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg <= '0;
            sum_reg        <= '0;
            version_reg    <= '0;
            hlen_reg       <= '0;
            ttl_reg        <= '0;
            dest_reg       <= '0;
        end else if (step) begin
            if (word_in.last_word) begin
                word_count_reg <= '0;
                sum_reg        <= '0;
                version_reg    <= '0;
                hlen_reg       <= '0;
                ttl_reg        <= '0;
                dest_reg       <= '0;
            end else begin
                word_count_reg <= word_count_next;
                sum_reg        <= sum_next;
                version_reg    <= version_next;
                hlen_reg       <= hlen_next;
                ttl_reg        <= ttl_next;
                dest_reg       <= dest_next;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ipv4_header_checker.sv
`default_nettype none

// IPv4 header checker. Takes one 16-bit packet word per cycle on s_* and gives
// one verdict on m_* for each word flagged last_word, once that word is taken
// and the input register feeds its per-word update into the result register.
// Throughput is one word per clock as long as m_ready keeps up; a held verdict
// stalls s_ready only once the input register is also full. local_address is
// written over cfg_* (always ready) and must only change between packets.
module ipv4_header_checker
    import ihc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ihc_in_t           s_data,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output ihc_out_t               m_data,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ADDR_W-1:0] cfg_data
);

    logic              in_valid_reg;
    ihc_in_t           in_data_reg;
    logic              out_valid_reg;
    ihc_out_t          out_data_reg;
    logic [ADDR_W-1:0] local_addr_reg;

    logic              advance;
    ihc_out_t          result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    ihc_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .word_in       (in_data_reg),
        .local_address (local_addr_reg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            local_addr_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && in_data_reg.last_word) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                local_addr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && in_data_reg.last_word) begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire
